// ===== sv/aahs_pkg.sv =====
package aahs_pkg;

  localparam logic [15:0] SCAN_LIMIT_RESET = 16'h1200;

  // match phase codes
  localparam logic [4:0] PH_SIG      = 5'd0;
  localparam logic [4:0] PH_SIG_END  = 5'd5;
  localparam logic [4:0] PH_SKIP_A   = 5'd6;
  localparam logic [4:0] PH_AUDS     = 5'd7;
  localparam logic [4:0] PH_AUDS_END = 5'd11;
  localparam logic [4:0] PH_SKIP_B   = 5'd12;
  localparam logic [4:0] PH_RATE     = 5'd13;
  localparam logic [4:0] PH_RATE_END = 5'd16;
  localparam logic [4:0] PH_SKIP_C   = 5'd17;
  localparam logic [4:0] PH_ALIGN    = 5'd18;
  localparam logic [4:0] PH_SKIP_D   = 5'd19;
  localparam logic [4:0] PH_CHAN     = 5'd20;
  localparam logic [4:0] PH_DONE     = 5'd21;

  localparam logic [4:0] SKIP_A_LEN = 5'd14;
  localparam logic [4:0] SKIP_B_LEN = 5'd19;
  localparam logic [4:0] SKIP_C_LEN = 5'd16;
  localparam logic [4:0] SKIP_D_LEN = 5'd21;

  typedef struct packed {
    logic [31:0] audio_rate;
    logic [7:0]  block_align;
    logic [7:0]  channel_count;
    logic        audio_ok;
  } aahs_result_t;

  // "LIST",0x7c,0x10
  function automatic logic [7:0] list_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h4c;
      3'd1: b = 8'h49;
      3'd2: b = 8'h53;
      3'd3: b = 8'h54;
      3'd4: b = 8'h7c;
      3'd5: b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // "auds",0x01
  function automatic logic [7:0] auds_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h61;
      3'd1: b = 8'h75;
      3'd2: b = 8'h64;
      3'd3: b = 8'h73;
      3'd4: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] skip_len(input logic [4:0] phase);
    logic [4:0] n;
    case (phase)
      PH_SKIP_A: n = SKIP_A_LEN;
      PH_SKIP_B: n = SKIP_B_LEN;
      PH_SKIP_C: n = SKIP_C_LEN;
      default:   n = SKIP_D_LEN;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/avi_audio_header_scan_unit.sv =====
// channel   signals                                      direction
// in        in_valid in_ready byte_value end_of_file     request in
// out       out_valid out_ready audio_rate block_align   result out
//           channel_count audio_ok
// cfg       cfg_we cfg_wdata (scan_limit)                write, no wait
//
// one byte per cycle while in_ready is high; the match state updates in the
// cycle the byte is taken; a two-entry result buffer drives out_valid
// in_ready drops only while both buffer entries hold untaken results
// rst is synchronous: scan_limit returns to 0x1200 and the scan to its start
module avi_audio_header_scan_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] audio_rate,
  output logic [7:0]  block_align,
  output logic [7:0]  channel_count,
  output logic        audio_ok,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import aahs_pkg::*;

  aahs_result_t res, buf_out;
  logic         res_push, take, buf_full;

  assign in_ready = !buf_full;
  assign take     = in_valid && in_ready;

  aahs_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .take       (take),
    .byte_value (byte_value),
    .end_of_file(end_of_file),
    .res_push   (res_push),
    .res        (res)
  );

  aahs_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .din       (res),
    .pop_ready (out_ready),
    .dout_valid(out_valid),
    .dout      (buf_out),
    .full      (buf_full)
  );

  assign audio_rate    = buf_out.audio_rate;
  assign block_align   = buf_out.block_align;
  assign channel_count = buf_out.channel_count;
  assign audio_ok      = buf_out.audio_ok;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  a_push_from_take: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (in_valid && in_ready))
    else $error("result produced without an accepted request");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (res_push && !out_valid) |=> out_valid)
    else $error("result into empty buffer not presented");

  a_ok_format: assert property (@(posedge clk) disable iff (rst)
    (out_valid && audio_ok) |-> (channel_count == 8'd1 && block_align[4:0] == 5'd1))
    else $error("audio_ok set for unsupported format");

endmodule

// ===== sv/aahs_scan.sv =====
module aahs_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  take,
  input  logic [7:0]            byte_value,
  input  logic                  end_of_file,
  output logic                  res_push,
  output aahs_pkg::aahs_result_t res
);
  import aahs_pkg::*;

  logic [15:0] scan_limit;
  logic [4:0]  match_phase, match_phase_next;
  logic [4:0]  skip_count, skip_count_next;
  logic [15:0] byte_position, byte_position_next;
  logic [31:0] rate_value, rate_value_next;
  logic [7:0]  align_value, align_value_next;
  logic [7:0]  channels_value, channels_value_next;

  logic [4:0]  c_phase, c_skip, ofs;
  logic [15:0] c_pos;
  logic [31:0] c_rate;
  logic [7:0]  c_align, c_chan;
  logic        finish, rewind;
  logic [31:0] r_rate;
  logic [7:0]  r_align, r_chan;
  logic        r_ok;

  // effect of one byte on the match state
  always_comb begin
    c_phase = match_phase;
    c_skip  = skip_count;
    c_rate  = rate_value;
    c_align = align_value;
    c_chan  = channels_value;
    ofs     = 5'd0;
    case (match_phase) inside
      [PH_SIG:PH_SIG_END]: begin
        c_phase = (byte_value == list_byte(match_phase[2:0])) ? match_phase + 5'd1 : PH_SIG;
      end
      PH_SKIP_A, PH_SKIP_B, PH_SKIP_C, PH_SKIP_D: begin
        c_skip = skip_count + 5'd1;
        if (c_skip >= skip_len(match_phase)) begin
          c_skip  = 5'd0;
          c_phase = match_phase + 5'd1;
        end
      end
      [PH_AUDS:PH_AUDS_END]: begin
        ofs = match_phase - PH_AUDS;
        c_phase = (byte_value == auds_byte(ofs[2:0])) ? match_phase + 5'd1 : PH_SIG;
      end
      [PH_RATE:PH_RATE_END]: begin
        ofs = match_phase - PH_RATE;
        case (ofs[1:0])
          2'd0: c_rate[7:0]   = byte_value;
          2'd1: c_rate[15:8]  = byte_value;
          2'd2: c_rate[23:16] = byte_value;
          default: c_rate[31:24] = byte_value;
        endcase
        c_phase = match_phase + 5'd1;
      end
      PH_ALIGN: begin
        c_align = byte_value;
        c_phase = PH_SKIP_D;
      end
      PH_CHAN: begin
        c_chan  = byte_value;
        c_phase = PH_SIG;
      end
      default: begin
        c_phase = PH_SIG;
        c_skip  = 5'd0;
      end
    endcase
    c_pos = (byte_position == 16'hffff) ? byte_position : byte_position + 16'd1;
  end

  always_comb begin
    match_phase_next    = match_phase;
    skip_count_next     = skip_count;
    byte_position_next  = byte_position;
    rate_value_next     = rate_value;
    align_value_next    = align_value;
    channels_value_next = channels_value;
    r_rate  = rate_value;
    r_align = align_value;
    r_chan  = channels_value;
    finish  = 1'b0;
    rewind  = 1'b0;
    if (match_phase == PH_DONE) begin
      rewind = end_of_file;
    end else if (match_phase == PH_SIG && byte_position >= scan_limit) begin
      // limit already reached: byte is dropped
      finish = 1'b1;
      rewind = end_of_file;
      match_phase_next = PH_DONE;
    end else begin
      match_phase_next    = c_phase;
      skip_count_next     = c_skip;
      byte_position_next  = c_pos;
      rate_value_next     = c_rate;
      align_value_next    = c_align;
      channels_value_next = c_chan;
      r_rate  = c_rate;
      r_align = c_align;
      r_chan  = c_chan;
      finish  = end_of_file || (c_phase == PH_SIG && c_pos >= scan_limit);
      rewind  = end_of_file;
      if (finish) match_phase_next = PH_DONE;
    end
    if (rewind) begin
      match_phase_next    = PH_SIG;
      skip_count_next     = 5'd0;
      byte_position_next  = 16'd0;
      rate_value_next     = 32'd0;
      align_value_next    = 8'd0;
      channels_value_next = 8'd0;
    end
  end

  // (align*8) mod 256 == 8 only depends on the low five bits
  assign r_ok = (r_chan == 8'd1) && (r_align[4:0] == 5'd1);

  assign res_push          = take && finish;
  assign res.audio_rate    = r_ok ? r_rate : 32'd0;
  assign res.block_align   = r_align;
  assign res.channel_count = r_chan;
  assign res.audio_ok      = r_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit     <= SCAN_LIMIT_RESET;
      match_phase    <= PH_SIG;
      skip_count     <= 5'd0;
      byte_position  <= 16'd0;
      rate_value     <= 32'd0;
      align_value    <= 8'd0;
      channels_value <= 8'd0;
    end else begin
      if (cfg_we) scan_limit <= cfg_wdata;
      if (take) begin
        match_phase    <= match_phase_next;
        skip_count     <= skip_count_next;
        byte_position  <= byte_position_next;
        rate_value     <= rate_value_next;
        align_value    <= align_value_next;
        channels_value <= channels_value_next;
      end
    end
  end

endmodule

// ===== sv/aahs_out_buf.sv =====
module aahs_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  aahs_pkg::aahs_result_t din,
  input  logic                   pop_ready,
  output logic                   dout_valid,
  output aahs_pkg::aahs_result_t dout,
  output logic                   full
);
  import aahs_pkg::*;

  aahs_result_t head, spare;
  logic [1:0]   fill;
  logic         pop;

  assign pop        = dout_valid && pop_ready;
  assign dout_valid = (fill != 2'd0);
  assign full       = (fill == 2'd2);
  assign dout       = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case (fill)
        2'd0: if (push) fill <= 2'd1;
        2'd1: begin
          if (push && !pop) fill <= 2'd2;
          else if (pop && !push) fill <= 2'd0;
        end
        default: if (pop) fill <= push ? 2'd2 : 2'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (fill)
      2'd0: if (push) head <= din;
      2'd1: begin
        if (push && pop) head <= din;
        else if (push) spare <= din;
      end
      default: begin
        if (pop) begin
          head  <= spare;
          if (push) spare <= din;
        end
      end
    endcase
  end

endmodule
